// ----- design/ptm_pkg.sv -----
package ptm_pkg;

  // Width of an IPv4 address and of the prefix length field.
  localparam int ADDR_BITS = 32;
  localparam int LEN_W     = 6;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Controls from the sequencer to the address bit shifter.
  typedef struct packed {
    logic load;
    logic step;
  } shift_ctl_t;

  // Status from the address bit shifter back to the sequencer.
  typedef struct packed {
    logic bit_val;
    logic rem_zero;
    logic rem_one;
  } shift_sts_t;

endpackage

// ----- design/ipv4_prefix_trie_match_core.sv -----
// Channel   Ports                                   Handshake
// command   command, address, prefix_len            start high while busy is low
// result    matched, pool_full                      done high for one cycle
//
// A query walks one trie level per cycle. An insert steps through each existing level,
// writes each new node and, unless it is a child of the root, writes its parent again to
// link it; an existing end node is marked with one more write.
// Clear, a zero-length insert and the unused command finish without leaving idle.
// Reset empties the table at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ipv4_prefix_trie_match_core #(
  parameter int NODES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic [ptm_pkg::ADDR_BITS-1:0]     address,
  input  logic [ptm_pkg::LEN_W-1:0]         prefix_len,
  output logic                              done,
  output logic                              matched,
  output logic                              pool_full
);
  import ptm_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam int NW = AW + 1;
  localparam int W  = 2 * AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_MARK = 2'd3;

  logic [1:0]    state, state_next;
  logic [AW-1:0] node, node_next;
  logic          is_root, is_root_next;
  logic          is_fresh, is_fresh_next;
  logic          is_query, is_query_next;
  logic [NW-1:0] next_free, next_free_next;
  logic [AW-1:0] root_one, root_one_next;
  logic [AW-1:0] root_zero, root_zero_next;
  logic [AW-1:0] pnode, pnode_next;
  logic [W-1:0]  pword, pword_next;
  logic          link_last, link_last_next;
  logic          done_next, matched_next, pool_full_next;

  shift_ctl_t    sctl;
  shift_sts_t    ssts;
  logic [LEN_W-1:0] load_len;

  logic          we;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [W-1:0]  rdata;

  logic [AW-1:0] cur_one, cur_zero, child, fresh_id;
  logic          cur_end;

  ptm_shift u_shift (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .load_addr (address),
    .load_len  (load_len),
    .sts       (ssts)
  );

  ptm_ram #(
    .WIDTH (W),
    .DEPTH (NODES)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (node_next),
    .rdata (rdata)
  );

  // A query walks the full address; an insert walks its prefix.
  assign load_len = (command == CMD_QUERY) ? LEN_W'(ADDR_BITS) : prefix_len;

  // The current node comes from the root registers, is a blank fresh node,
  // or was read from the node memory in the previous cycle.
  always_comb begin
    if (is_root) begin
      cur_one  = root_one;
      cur_zero = root_zero;
      cur_end  = 1'b0;
    end else if (is_fresh) begin
      cur_one  = '0;
      cur_zero = '0;
      cur_end  = 1'b0;
    end else begin
      cur_one  = rdata[2*AW-1:AW];
      cur_zero = rdata[AW-1:0];
      cur_end  = rdata[W-1];
    end
  end

  assign child    = ssts.bit_val ? cur_one : cur_zero;
  assign fresh_id = next_free[AW-1:0];

  // Sequencer: one trie level per walk cycle.
  always_comb begin
    state_next     = state;
    node_next      = node;
    is_root_next   = is_root;
    is_fresh_next  = is_fresh;
    is_query_next  = is_query;
    next_free_next = next_free;
    root_one_next  = root_one;
    root_zero_next = root_zero;
    pnode_next     = pnode;
    pword_next     = pword;
    link_last_next = link_last;
    done_next      = 1'b0;
    matched_next   = matched;
    pool_full_next = pool_full;
    sctl.load      = 1'b0;
    sctl.step      = 1'b0;
    we             = 1'b0;
    waddr          = node;
    wdata          = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          matched_next   = 1'b0;
          pool_full_next = 1'b0;
          is_root_next   = 1'b1;
          is_fresh_next  = 1'b0;
          is_query_next  = (command == CMD_QUERY);
          node_next      = '0;
          case (command)
            CMD_CLEAR: begin
              root_one_next  = '0;
              root_zero_next = '0;
              next_free_next = NW'(1);
              done_next      = 1'b1;
            end
            CMD_INSERT: begin
              if (prefix_len == '0) begin
                done_next = 1'b1;
              end else begin
                sctl.load  = 1'b1;
                state_next = S_WALK;
              end
            end
            CMD_QUERY: begin
              sctl.load  = 1'b1;
              state_next = S_WALK;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        if (is_query) begin
          // Query: stop at the first marked node, the first missing child or the end of the address.
          if (cur_end) begin
            matched_next = 1'b1;
            done_next    = 1'b1;
            state_next   = S_IDLE;
          end else if (ssts.rem_zero || child == '0) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            node_next     = child;
            is_root_next  = 1'b0;
            is_fresh_next = 1'b0;
            sctl.step     = 1'b1;
          end
        end else if (child != '0) begin
          // Insert through an existing node.
          node_next     = child;
          is_root_next  = 1'b0;
          is_fresh_next = 1'b0;
          sctl.step     = 1'b1;
          if (ssts.rem_one) begin
            state_next = S_MARK;
          end
        end else if (next_free == NW'(NODES)) begin
          pool_full_next = 1'b1;
          done_next      = 1'b1;
          state_next     = S_IDLE;
        end else begin
          // Allocate a blank node, marked when it ends the prefix.
          we             = 1'b1;
          waddr          = fresh_id;
          wdata          = {ssts.rem_one, {(2*AW){1'b0}}};
          next_free_next = next_free + NW'(1);
          node_next      = fresh_id;
          is_fresh_next  = 1'b1;
          is_root_next   = 1'b0;
          sctl.step      = 1'b1;
          if (is_root) begin
            if (ssts.bit_val) begin
              root_one_next = fresh_id;
            end else begin
              root_zero_next = fresh_id;
            end
            if (ssts.rem_one) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            pnode_next     = node;
            pword_next     = {cur_end,
                              ssts.bit_val ? fresh_id : cur_one,
                              ssts.bit_val ? cur_zero : fresh_id};
            link_last_next = ssts.rem_one;
            state_next     = S_LINK;
          end
        end
      end

      S_LINK: begin
        // Hook the fresh node into its parent.
        we    = 1'b1;
        waddr = pnode;
        wdata = pword;
        if (link_last) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_WALK;
        end
      end

      S_MARK: begin
        // Mark an existing node as the end of the prefix.
        we         = 1'b1;
        waddr      = node;
        wdata      = {1'b1, rdata[2*AW-1:0]};
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and the root node.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      next_free <= NW'(1);
      root_one  <= '0;
      root_zero <= '0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      next_free <= next_free_next;
      root_one  <= root_one_next;
      root_zero <= root_zero_next;
    end
  end

  // Walk context and result payload.
  always_ff @(posedge clk) begin
    node      <= node_next;
    is_root   <= is_root_next;
    is_fresh  <= is_fresh_next;
    is_query  <= is_query_next;
    pnode     <= pnode_next;
    pword     <= pword_next;
    link_last <= link_last_next;
    matched   <= matched_next;
    pool_full <= pool_full_next;
  end

  assign busy = (state != S_IDLE);

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the sequencer is still working");

  // An accepted transaction either starts a walk or finishes at once.
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither started nor finished");

  // The allocator never runs past the end of the node pool.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NW'(NODES))
    else $error("node allocator beyond pool size");

  // A transaction never reports both a match and a full pool.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(matched && pool_full))
    else $error("match and pool full reported together");

  // Marking follows a step through an existing node, whose word is now read.
  a_mark_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> ($past(state) == S_WALK && !is_fresh))
    else $error("mark cycle without a preceding walk step");

endmodule

// ----- design/ptm_ram.sv -----
module ptm_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ptm_shift.sv -----
module ptm_shift (
  input  logic                                clk,
  input  logic                                rst,
  input  ptm_pkg::shift_ctl_t                 ctl,
  input  logic [ptm_pkg::ADDR_BITS-1:0]       load_addr,
  input  logic [ptm_pkg::LEN_W-1:0]           load_len,
  output ptm_pkg::shift_sts_t                 sts
);
  import ptm_pkg::*;

  logic [ADDR_BITS-1:0] addr_sr;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     len_sat;

  // Prefix lengths above the address width are clamped to a full address.
  assign len_sat = (load_len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : load_len;

  // The address moves out one bit per trie level, most significant bit first.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ctl.load) begin
      rem <= len_sat;
    end else if (ctl.step && rem != '0) begin
      rem <= rem - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      addr_sr <= load_addr;
    end else if (ctl.step) begin
      addr_sr <= {addr_sr[ADDR_BITS-2:0], 1'b0};
    end
  end

  assign sts.bit_val  = addr_sr[ADDR_BITS-1];
  assign sts.rem_zero = (rem == '0);
  assign sts.rem_one  = (rem == LEN_W'(1));

endmodule
